>>> rtl/egas_pkg.sv
// egas_pkg: shared types, constants and command/status structs
// used by the epsilon-greedy select controller, datapath and top level

package egas_pkg;

	localparam int NumStates  = 256;
	localparam int NumChoices = 8;
	localparam int StateW     = 8;
	localparam int ChoiceW    = 3;
	localparam int CountW     = 4;
	localparam int ValueW     = 32;
	localparam int ProbW      = 17;
	localparam int EpsW       = 16;
	localparam int AddrW      = StateW + ChoiceW;
	localparam int NumW       = 20;
	localparam int DenW       = 7;
	localparam int CfgIdxW    = 1;

	localparam logic [CfgIdxW-1:0] CFG_EPSILON = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_INUSE   = 1'd1;

	localparam logic [1:0] ACT_WRITE_VALUE = 2'd0;
	localparam logic [1:0] ACT_WRITE_MASK  = 2'd1;
	localparam logic [1:0] ACT_SELECT      = 2'd2;

	localparam logic [EpsW-1:0] EPS_RESET   = 16'd6554;
	localparam logic [CountW-1:0] INUSE_RESET = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_PICK,
		ST_DIV,
		ST_DONE
	} egas_state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic load;
		logic scan_step;
		logic pick;
		logic div_start;
		logic div_step;
		logic finish;
	} egas_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic scan_last;
		logic div_last;
		logic is_select;
	} egas_status_t;

endpackage

>>> rtl/epsilon_greedy_action_select_unit.sv
// epsilon_greedy_action_select_unit: top level of the epsilon-greedy select unit
// depends on egas_pkg, egas_ctrl and egas_datapath
//
// usage:
//   in_valid/in_ready carries one request: write value (action 0), write allowed
//   mask (action 1) or select (action 2); action 3 is a no-op
//   out_valid/out_ready returns one result per request; write and no-op
//   requests give all-zero results
//   cfg_we/cfg_index/cfg_data write epsilon (index 0) and choices in use (1)
//   while the unit is idle
// timing:
//   each request scans the eight stored values; a select then adds a pick step
//   and a restoring divider; the last step loads the result register
//   one request in flight; the next is taken the cycle after the result loads
// reset:
//   a clearing pass zeroes the value memory and sets all masks after
//   arst_n releases; no request is accepted during it
// stall:
//   a result holds until out_ready; the next request still runs, then waits in
//   its last step until the result register frees

module epsilon_greedy_action_select_unit
	import egas_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [EpsW-1:0]          cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               action,
	input  logic [StateW-1:0]        state_index,
	input  logic [ChoiceW-1:0]       choice_index,
	input  logic signed [ValueW-1:0] new_value,
	input  logic [NumChoices-1:0]    allowed_mask,
	input  logic [EpsW-1:0]          explore_random,
	input  logic [EpsW-1:0]          pick_random,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ChoiceW-1:0]       chosen_choice,
	output logic                     explored,
	output logic [CountW-1:0]        tied_count,
	output logic [CountW-1:0]        allowed_count,
	output logic signed [ValueW-1:0] value_read,
	output logic [ProbW-1:0]         probability,
	output logic                     empty_flag
);

	egas_cmd_t    cmd;
	egas_status_t status;

	egas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	egas_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_index),
		.cfg_data       (cfg_data),
		.action         (action),
		.state_index    (state_index),
		.choice_index   (choice_index),
		.new_value      (new_value),
		.allowed_mask   (allowed_mask),
		.explore_random (explore_random),
		.pick_random    (pick_random),
		.chosen_choice  (chosen_choice),
		.explored       (explored),
		.tied_count     (tied_count),
		.allowed_count  (allowed_count),
		.value_read     (value_read),
		.probability    (probability),
		.empty_flag     (empty_flag)
	);

endmodule

>>> rtl/egas_ctrl.sv
// egas_ctrl: controller state machine for the select unit
// depends on egas_pkg command and status types

module egas_ctrl
	import egas_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  egas_status_t status,
	output egas_cmd_t    cmd
);

	egas_state_t state_q, state_d;
	logic        out_valid_q;
	logic        res_free;

	// result register can take a new result
	assign res_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (status.clear_last) state_d = ST_IDLE;
			ST_IDLE: if (in_valid) state_d = ST_SCAN;
			ST_SCAN: begin
				if (status.scan_last) state_d = status.is_select ? ST_PICK : ST_DONE;
			end
			ST_PICK: state_d = ST_DIV;
			ST_DIV: if (status.div_last) state_d = ST_DONE;
			ST_DONE: if (res_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clear_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_PICK: begin
				cmd.pick = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_DONE: cmd.finish = res_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/egas_datapath.sv
// egas_datapath: value and mask memories, max scan, pick and serial divider
// depends on egas_pkg; driven by egas_ctrl commands

module egas_datapath
	import egas_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  egas_cmd_t                cmd,
	output egas_status_t             status,
	input  logic                     cfg_we,
	input  logic [CfgIdxW-1:0]       cfg_idx,
	input  logic [EpsW-1:0]          cfg_data,
	input  logic [1:0]               action,
	input  logic [StateW-1:0]        state_index,
	input  logic [ChoiceW-1:0]       choice_index,
	input  logic signed [ValueW-1:0] new_value,
	input  logic [NumChoices-1:0]    allowed_mask,
	input  logic [EpsW-1:0]          explore_random,
	input  logic [EpsW-1:0]          pick_random,
	output logic [ChoiceW-1:0]       chosen_choice,
	output logic                     explored,
	output logic [CountW-1:0]        tied_count,
	output logic [CountW-1:0]        allowed_count,
	output logic signed [ValueW-1:0] value_read,
	output logic [ProbW-1:0]         probability,
	output logic                     empty_flag
);

	// config registers
	logic [EpsW-1:0]   eps_q;
	logic [CountW-1:0] inuse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q   <= EPS_RESET;
			inuse_q <= INUSE_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_EPSILON) eps_q <= cfg_data;
			else if (cfg_idx == CFG_INUSE) inuse_q <= cfg_data[CountW-1:0];
		end
	end

	// latched request
	logic [1:0]            act_q;
	logic [StateW-1:0]     st_q;
	logic [ChoiceW-1:0]    ch_q;
	logic [ValueW-1:0]     nv_q;
	logic [NumChoices-1:0] nm_q;
	logic [EpsW-1:0]       er_q, pr_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			st_q  <= state_index;
			ch_q  <= choice_index;
			nv_q  <= new_value;
			nm_q  <= allowed_mask;
			er_q  <= explore_random;
			pr_q  <= pick_random;
		end
	end

	// clear sweep and scan counters
	logic [AddrW:0]   clr_q;
	logic [ChoiceW:0] scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			scan_q <= '0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (cmd.load) scan_q <= '0;
			else if (cmd.scan_step) scan_q <= scan_q + 1'b1;
		end
	end

	// value memory and mask memory
	logic [ValueW-1:0]     vmem [2**AddrW];
	logic [NumChoices-1:0] mmem [NumStates];
	logic [ValueW-1:0]     vrd_q;
	logic [NumChoices-1:0] mrd_q;
	logic                  scan_valid_s1;
	logic [ChoiceW-1:0]    scan_idx_s1;
	logic                  scan_step_s1;

	logic [AddrW-1:0] rd_addr;
	assign rd_addr = {st_q, scan_q[ChoiceW-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.clear_step) vmem[clr_q[AddrW-1:0]] <= '0;
		else if (cmd.scan_step && scan_q == '0 && act_q == ACT_WRITE_VALUE)
			vmem[{st_q, ch_q}] <= nv_q;
		vrd_q <= vmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) mmem[clr_q[AddrW-1:StateW-StateW+ChoiceW]] <= '1;
		else if (cmd.scan_step && scan_q == '0 && act_q == ACT_WRITE_MASK)
			mmem[st_q] <= nm_q;
		mrd_q <= mmem[st_q];
	end

	always_ff @(posedge clk) begin
		scan_step_s1  <= cmd.scan_step;
		scan_idx_s1   <= scan_q[ChoiceW-1:0];
		scan_valid_s1 <= cmd.scan_step && scan_q < (ChoiceW+1)'(NumChoices);
	end

	// active choice mask
	logic [NumChoices-1:0] active;
	always_comb begin
		for (int i = 0; i < NumChoices; i++) active[i] = (CountW'(i) < inuse_q);
	end

	logic [NumChoices-1:0] allowed;
	assign allowed = mrd_q & active;

	// running maximum over the allowed stored values
	logic [NumChoices-1:0] tied_q;
	logic [ValueW-1:0]     best_q;
	logic                  have_q;
	logic [ValueW-1:0]     key;
	logic [ValueW-1:0]     qval_q;
	assign key = vrd_q ^ {1'b1, {(ValueW-1){1'b0}}};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tied_q <= '0;
			have_q <= 1'b0;
		end else if (scan_step_s1 && scan_valid_s1) begin
			if (scan_idx_s1 == ch_q) qval_q <= vrd_q;
			if (allowed[scan_idx_s1]) begin
				if (!have_q || key > best_q) begin
					best_q <= key;
					tied_q <= NumChoices'(1) << scan_idx_s1;
					have_q <= 1'b1;
				end else if (key == best_q) begin
					tied_q[scan_idx_s1] <= 1'b1;
				end
			end
		end
	end

	// scan reads the eight stored values, with a final step to land the last read
	assign status.scan_last  = scan_q == (ChoiceW+1)'(NumChoices);
	assign status.clear_last = clr_q == (AddrW+1)'(2**AddrW - 1);
	assign status.is_select  = act_q == ACT_SELECT;

	// counts and nth-member pick
	function automatic logic [CountW-1:0] popc(input logic [NumChoices-1:0] m);
		logic [CountW-1:0] n;
		n = '0;
		for (int i = 0; i < NumChoices; i++) n = n + CountW'(m[i]);
		return n;
	endfunction

	function automatic logic [ChoiceW-1:0] nth(input logic [NumChoices-1:0] m,
			input logic [CountW-1:0] k);
		logic [ChoiceW-1:0] r;
		logic [CountW-1:0]  c;
		r = '0;
		c = '0;
		for (int i = 0; i < NumChoices; i++) begin
			if (m[i]) begin
				if (c == k) r = ChoiceW'(i);
				c = c + 1'b1;
			end
		end
		return r;
	endfunction

	logic [CountW-1:0] na, nt, n_sel;
	logic              expl;
	logic [EpsW+CountW-1:0] prod;
	assign na    = popc(allowed);
	assign nt    = popc(tied_q);
	assign expl  = er_q < eps_q;
	assign n_sel = expl ? na : nt;
	assign prod  = pr_q * n_sel;

	logic [ChoiceW-1:0] chosen_q;
	logic               expl_q, empty_q;
	logic [CountW-1:0]  na_q, nt_q;
	logic [1:0]         pcase_q;

	// numerator and denominator for the probability
	logic [NumW-1:0] num_tied, num_eps;
	logic [DenW-1:0] den_tied;
	assign num_tied = NumW'(eps_q) * NumW'(nt)
		+ NumW'(17'h10000 - {1'b0, eps_q}) * NumW'(na);
	assign num_eps  = NumW'(eps_q);
	assign den_tied = DenW'(na) * DenW'(nt);

	// restoring divider, one quotient bit per cycle
	logic [NumW-1:0]   dq_q;
	logic [DenW:0]     rem_q;
	logic [DenW-1:0]   den_q;
	logic [4:0]        dcnt_q;
	logic [DenW:0]     trial;
	logic [DenW+1:0]   shifted;
	assign shifted = {rem_q, dq_q[NumW-1]};
	assign trial   = DenW'(0) + shifted[DenW:0] - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			empty_q  <= na == '0;
			na_q     <= na;
			nt_q     <= nt;
			expl_q   <= expl;
			chosen_q <= nth(expl ? allowed : tied_q, prod[EpsW+CountW-1:EpsW]);
			if (tied_q[ch_q]) begin
				pcase_q <= 2'd2;
				dq_q    <= num_tied;
				den_q   <= den_tied;
			end else if (allowed[ch_q]) begin
				pcase_q <= 2'd1;
				dq_q    <= num_eps;
				den_q   <= DenW'(na);
			end else begin
				pcase_q <= 2'd0;
				dq_q    <= '0;
				den_q   <= DenW'(1);
			end
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= trial;
				dq_q  <= {dq_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DenW:0];
				dq_q  <= {dq_q[NumW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	assign status.div_last = cmd.div_step && dcnt_q == 5'(NumW - 1);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			chosen_choice <= '0;
			explored      <= 1'b0;
			tied_count    <= '0;
			allowed_count <= '0;
			value_read    <= '0;
			probability   <= '0;
			empty_flag    <= 1'b0;
			if (act_q == ACT_SELECT) begin
				value_read <= qval_q;
				if (empty_q) begin
					empty_flag <= 1'b1;
				end else begin
					chosen_choice <= chosen_q;
					explored      <= expl_q;
					tied_count    <= nt_q;
					allowed_count <= na_q;
					probability   <= (pcase_q == 2'd0) ? '0 : ProbW'(dq_q);
				end
			end
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for epsilon_greedy_action_select_unit
// depends on egas_pkg and the unit; scoreboard class predicts each result

module tb_top
	import egas_pkg::*;
();

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [ChoiceW-1:0] choice;
		logic               expl;
		logic [CountW-1:0]  tied;
		logic [CountW-1:0]  allowed;
		logic [ValueW-1:0]  value;
		logic [ProbW-1:0]   prob;
		logic               empty;
	} pick_result_t;

	int err_count = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// policy predictor and pending results
	class policy_scoreboard;
		logic [ValueW-1:0]     values [NumStates][NumChoices];
		logic [NumChoices-1:0] masks [NumStates];
		logic [EpsW-1:0]       epsilon;
		logic [3:0]            in_use;
		pick_result_t          pending [$];

		function new();
			foreach (values[s, c]) values[s][c] = '0;
			foreach (masks[s]) masks[s] = '1;
			epsilon = EPS_RESET;
			in_use = INUSE_RESET;
		endfunction

		function void set_reg(logic idx, logic [EpsW-1:0] d);
			if (idx == CFG_EPSILON) epsilon = d;
			else in_use = d[3:0];
		endfunction

		function int nth_member(logic [NumChoices-1:0] m, int k);
			for (int i = 0; i < NumChoices; i++)
				if (m[i]) begin
					if (k == 0) return i;
					k--;
				end
			return 0;
		endfunction

		function void note_request(logic [1:0] act, logic [StateW-1:0] st,
				logic [ChoiceW-1:0] ch, logic [ValueW-1:0] nv, logic [NumChoices-1:0] am,
				logic [EpsW-1:0] er, logic [EpsW-1:0] pr);
			pick_result_t r;
			logic [NumChoices-1:0] act_mask, allow, tie;
			logic [ValueW-1:0] best_key, key;
			bit have;
			int inuse, na, nt, n;
			longint unsigned num, den;
			r = '{default: '0};
			if (act == ACT_WRITE_VALUE) values[st][ch] = nv;
			else if (act == ACT_WRITE_MASK) masks[st] = am;
			else if (act == ACT_SELECT) begin
				inuse = in_use > NumChoices ? NumChoices : in_use;
				act_mask = NumChoices'((9'd1 << inuse) - 9'd1);
				allow = masks[st] & act_mask;
				r.value = values[st][ch];
				na = $countones(allow);
				if (na == 0) r.empty = 1;
				else begin
					have = 0; tie = '0; best_key = '0;
					for (int i = 0; i < NumChoices; i++)
						if (allow[i]) begin
							key = values[st][i] ^ 32'h8000_0000;
							if (!have || key > best_key) begin
								best_key = key; tie = '0; tie[i] = 1; have = 1;
							end else if (key == best_key) tie[i] = 1;
						end
					nt = $countones(tie);
					if (er < epsilon) begin
						r.expl = 1; n = na;
						r.choice = ChoiceW'(nth_member(allow, (int'(pr) * n) >> 16));
					end else begin
						n = nt;
						r.choice = ChoiceW'(nth_member(tie, (int'(pr) * n) >> 16));
					end
					if (tie[ch]) begin
						num = longint'(epsilon) * nt + (65536 - longint'(epsilon)) * na;
						den = longint'(na * nt);
						r.prob = ProbW'(num / den);
					end else if (allow[ch]) r.prob = ProbW'(int'(epsilon) / na);
					r.tied = CountW'(nt);
					r.allowed = CountW'(na);
				end
			end
			pending = {pending, r};
		endfunction

		task check_result(pick_result_t got);
			pick_result_t w;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
				return;
			end
			w = pending.pop_front();
			if (got.choice !== w.choice) report_mismatch("chosen_choice", got.choice, w.choice);
			if (got.expl !== w.expl) report_mismatch("explored", got.expl, w.expl);
			if (got.tied !== w.tied) report_mismatch("tied_count", got.tied, w.tied);
			if (got.allowed !== w.allowed)
				report_mismatch("allowed_count", got.allowed, w.allowed);
			if (got.value !== w.value) report_mismatch("value_read", got.value, w.value);
			if (got.prob !== w.prob) report_mismatch("probability", got.prob, w.prob);
			if (got.empty !== w.empty) report_mismatch("empty_flag", got.empty, w.empty);
		endtask
	endclass

	logic clk, arst_n;
	logic cfg_we, cfg_index;
	logic [EpsW-1:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] action;
	logic [StateW-1:0] state_index;
	logic [ChoiceW-1:0] choice_index;
	logic signed [ValueW-1:0] new_value;
	logic [NumChoices-1:0] allowed_mask;
	logic [EpsW-1:0] explore_random, pick_random;
	logic [ChoiceW-1:0] chosen_choice;
	logic explored, empty_flag;
	logic [CountW-1:0] tied_count, allowed_count;
	logic signed [ValueW-1:0] value_read;
	logic [ProbW-1:0] probability;

	policy_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycle_count = 0;

	epsilon_greedy_action_select_unit DUT (.*);

	// clock and reset
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: random stall, check at accept
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result('{chosen_choice, explored, tied_count, allowed_count,
				value_read, probability, empty_flag});
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// valid stays high from one request to the next unless the sender idles
	task automatic send_request(logic [1:0] act, logic [StateW-1:0] st, logic [ChoiceW-1:0] ch,
			logic [ValueW-1:0] nv, logic [NumChoices-1:0] am, logic [EpsW-1:0] er,
			logic [EpsW-1:0] pr);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1;
		action <= act; state_index <= st; choice_index <= ch; new_value <= nv;
		allowed_mask <= am; explore_random <= er; pick_random <= pr;
		do @(posedge clk); while (!in_ready);
		sb.note_request(act, st, ch, nv, am, er, pr);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [EpsW-1:0] d);
		drain();
		cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, d);
	endtask

	// random request; mostly small state set so selects see written data
	task automatic random_request();
		logic [1:0] act;
		logic [StateW-1:0] st;
		logic [ValueW-1:0] nv;
		int k;
		k = $urandom_range(99);
		act = k < 35 ? ACT_WRITE_VALUE : k < 45 ? ACT_WRITE_MASK : k < 97 ? ACT_SELECT : ACT_UNUSED;
		st = ($urandom_range(3) == 0) ? StateW'($urandom) : StateW'($urandom_range(7));
		nv = ($urandom_range(1) == 0) ? ValueW'($urandom_range(3) - 1) : ValueW'($urandom);
		send_request(act, st, ChoiceW'($urandom), nv,
			($urandom_range(4) == 0) ? 8'h00 : NumChoices'($urandom),
			EpsW'($urandom), EpsW'($urandom));
	endtask

	initial begin
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; action = 0; state_index = 0; choice_index = 0; new_value = 0;
		allowed_mask = 0; explore_random = 0; pick_random = 0;
		@(posedge arst_n);

		// directed: reset state, extremes, empty, ties, unused kind
		send_request(ACT_SELECT, 0, 0, 0, 0, 0, 0);
		send_request(ACT_SELECT, 255, 7, 0, 0, 16'hFFFF, 16'hFFFF);
		send_request(ACT_WRITE_VALUE, 1, 0, 32'h7FFF_FFFF, 0, 0, 0);
		send_request(ACT_WRITE_VALUE, 1, 7, 32'h8000_0000, 0, 0, 0);
		send_request(ACT_WRITE_VALUE, 1, 3, 32'h7FFF_FFFF, 0, 0, 0);
		send_request(ACT_SELECT, 1, 3, 0, 0, 16'hFFFF, 16'hFFFF);
		send_request(ACT_SELECT, 1, 7, 0, 0, 0, 16'hFFFF);
		send_request(ACT_SELECT, 1, 5, 0, 0, 16'hFFFF, 0);
		send_request(ACT_WRITE_MASK, 2, 0, 0, 8'h00, 0, 0);
		send_request(ACT_SELECT, 2, 4, 0, 0, 0, 0);
		send_request(ACT_WRITE_MASK, 2, 0, 0, 8'h80, 0, 0);
		send_request(ACT_SELECT, 2, 7, 0, 0, 16'hFFFF, 16'hFFFF);
		send_request(ACT_WRITE_MASK, 2, 0, 0, 8'hFF, 0, 0);
		send_request(ACT_UNUSED, 2, 2, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_request(ACT_SELECT, 2, 2, 0, 0, 16'hFFFF, 16'h8000);
		write_reg(CFG_EPSILON, 16'hFFFF);
		send_request(ACT_SELECT, 1, 3, 0, 0, 0, 16'h4000);
		write_reg(CFG_EPSILON, 0);
		write_reg(CFG_INUSE, 0);
		send_request(ACT_SELECT, 1, 0, 0, 0, 0, 0);
		write_reg(CFG_INUSE, 15);
		send_request(ACT_SELECT, 1, 0, 0, 0, 0, 16'hFFFF);
		write_reg(CFG_INUSE, 1);
		send_request(ACT_SELECT, 1, 0, 0, 0, 0, 0);

		// random phases with different config and idling
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_EPSILON, ph == 0 ? 16'd0 : ph == 1 ? 16'hFFFF : EpsW'($urandom));
			write_reg(CFG_INUSE, ph == 2 ? 4'd0 : ph == 3 ? 4'd1 : 4'($urandom_range(15)));
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			for (int i = 0; i < 200; i++) begin
				if (i == 100) drain();
				random_request();
			end
		end

		drain();
		if (err_count == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
